// File: hw/rtl/bcgd_pkg.sv
// Package for the button click gesture detector.
// Holds gesture codes, register indexes, reset values and the config struct.
// No dependencies.
`default_nettype none

package bcgd_pkg;

   localparam int unsigned TIME_BITS_DEFAULT = 32;
   localparam int unsigned CFG_BITS          = 24;
   localparam int unsigned CFG_INDEX_BITS    = 2;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET     = 24'd50000;
   localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RESET = 24'd300000;
   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET   = 24'd1000000;

   typedef enum logic [1:0] {
      GESTURE_NONE   = 2'd0,
      GESTURE_SINGLE = 2'd1,
      GESTURE_DOUBLE = 2'd2,
      GESTURE_LONG   = 2'd3
   } gesture_type;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_DEBOUNCE     = 2'd0,
      REG_DOUBLE_CLICK = 2'd1,
      REG_LONG_PRESS   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_us;
      logic [CFG_BITS-1:0] double_click_us;
      logic [CFG_BITS-1:0] long_press_us;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/bcgd_if.sv
// Handshake interfaces for the poll, result and register write channels.
// Depends on bcgd_pkg.
`default_nettype none

interface bcgd_req_if #(
   parameter int unsigned TIME_BITS = bcgd_pkg::TIME_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic                 pin_level;
   logic [TIME_BITS-1:0] time_us;

   modport source (output valid, output pin_level, output time_us, input ready);
   modport sink   (input valid, input pin_level, input time_us, output ready);
endinterface

interface bcgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] gesture;

   modport source (output valid, output gesture, input ready);
   modport sink   (input valid, input gesture, output ready);
endinterface

interface bcgd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bcgd_pkg::CFG_INDEX_BITS-1:0] index;
   logic [bcgd_pkg::CFG_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/button_click_gesture_detector_top.sv
// Button click gesture detector: a poll beat goes through the input register,
// then the detector logic into the result register. Throughput one poll per
// cycle while results are taken; the result register lets a new poll in while
// a result waits. Synchronous active-high reset restores the register reset
// values and a released, idle button. Depends on bcgd_pkg, bcgd_if, bcgd_core.
`default_nettype none

module button_click_gesture_detector_top #(
   parameter int unsigned TIME_BITS = bcgd_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bcgd_req_if.sink    req_bus,
   bcgd_rsp_if.source  rsp_bus,
   bcgd_csr_if.sink    csr_bus
);
   import bcgd_pkg::*;

   cfg_type              cfg_ff;
   logic                 s1_valid_ff;
   logic                 s1_pin_ff;
   logic [TIME_BITS-1:0] s1_time_ff;
   logic                 rsp_valid_ff;
   gesture_type          rsp_gesture_ff;
   gesture_type          gesture;
   logic                 s1_fire;
   logic                 req_fire;

   assign s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.gesture = rsp_gesture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_us     <= DEBOUNCE_RESET;
         cfg_ff.double_click_us <= DOUBLE_CLICK_RESET;
         cfg_ff.long_press_us   <= LONG_PRESS_RESET;
      end else if (csr_bus.valid) begin
         case (reg_index_type'(csr_bus.index))
            REG_DEBOUNCE:     cfg_ff.debounce_us     <= csr_bus.data;
            REG_DOUBLE_CLICK: cfg_ff.double_click_us <= csr_bus.data;
            REG_LONG_PRESS:   cfg_ff.long_press_us   <= csr_bus.data;
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pin_ff  <= req_bus.pin_level;
         s1_time_ff <= req_bus.time_us;
      end
      if (s1_fire) begin
         rsp_gesture_ff <= gesture;
      end
   end

   bcgd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (s1_fire),
      .pin_level (s1_pin_ff),
      .time_us   (s1_time_ff),
      .gesture   (gesture)
   );

`ifndef SYNTH
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready))
      else $error("poll stalled without a waiting result");
   a_fill_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted poll lost before detector stage");
   a_fill_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("detector step produced no result beat");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bcgd_core.sv
// Debounce, click tally and gesture decision for one poll per step.
// Holds the detector state; depends on bcgd_pkg.
`default_nettype none

module bcgd_core #(
   parameter int unsigned TIME_BITS = bcgd_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bcgd_pkg::cfg_type     cfg,
   input  wire logic                  step,
   input  wire logic                  pin_level,
   input  wire logic [TIME_BITS-1:0]  time_us,
   output bcgd_pkg::gesture_type      gesture
);
   import bcgd_pkg::*;

   localparam int unsigned CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

   logic                 level_ff, level_in;
   logic                 held_ff, held_in;
   logic                 long_ff, long_in;
   logic                 pend_ff, pend_in;
   logic [1:0]           tally_ff, tally_in;
   logic [TIME_BITS-1:0] change_ff, change_in;
   logic [TIME_BITS-1:0] press_ff, press_in;
   logic [TIME_BITS-1:0] release_ff, release_in;

   logic [TIME_BITS-1:0] el_change, el_press, el_release;
   logic                 level_change;

   always_comb begin
      level_in   = level_ff;
      held_in    = held_ff;
      long_in    = long_ff;
      pend_in    = pend_ff;
      tally_in   = tally_ff;
      change_in  = change_ff;
      press_in   = press_ff;
      release_in = release_ff;
      gesture    = GESTURE_NONE;

      el_change    = time_us - change_ff;
      level_change = (pin_level != level_ff) &&
                     (CMP_BITS'(el_change) > CMP_BITS'(cfg.debounce_us));

      if (level_change) begin
         change_in = time_us;
         level_in  = pin_level;
         if (!pin_level) begin
            press_in = time_us;
            held_in  = 1'b1;
            long_in  = 1'b0;
         end else begin
            release_in = time_us;
            held_in    = 1'b0;
            if (!long_ff) begin
               if (tally_ff != 2'd3) begin
                  tally_in = tally_ff + 2'd1;
               end
               pend_in = 1'b1;
            end
         end
      end

      el_press = time_us - press_in;
      if (held_in && !long_in &&
          (CMP_BITS'(el_press) > CMP_BITS'(cfg.long_press_us))) begin
         long_in  = 1'b1;
         tally_in = 2'd0;
         gesture  = GESTURE_LONG;
      end

      el_release = time_us - release_in;
      if (pend_in && !held_in &&
          (CMP_BITS'(el_release) > CMP_BITS'(cfg.double_click_us))) begin
         pend_in = 1'b0;
         case (tally_in)
            2'd1:    gesture = GESTURE_SINGLE;
            2'd2:    gesture = GESTURE_DOUBLE;
            default: gesture = GESTURE_NONE;
         endcase
         tally_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b1;
         held_ff    <= 1'b0;
         long_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         tally_ff   <= 2'd0;
         change_ff  <= '0;
         press_ff   <= '0;
         release_ff <= '0;
      end else if (step) begin
         level_ff   <= level_in;
         held_ff    <= held_in;
         long_ff    <= long_in;
         pend_ff    <= pend_in;
         tally_ff   <= tally_in;
         change_ff  <= change_in;
         press_ff   <= press_in;
         release_ff <= release_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/tb_button_click_gesture_detector_top.sv
// Testbench for button_click_gesture_detector_top: drives button polls and register
// writes, predicts the gesture per poll and checks every result beat in order.
// Depends on bcgd_pkg, bcgd_if and the detector RTL.

module tb_button_click_gesture_detector_top;
   import bcgd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct packed {
      logic        pin_level;
      logic [31:0] time_us;
   } poll_type;

   logic clock = 1'b0;
   logic reset;

   bcgd_req_if #(.TIME_BITS(32)) req_bus();
   bcgd_rsp_if rsp_bus();
   bcgd_csr_if csr_bus();

   button_click_gesture_detector_top #(.TIME_BITS(32)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow registers and detector state
   cfg_type     shadow_cfg = '{DEBOUNCE_RESET, DOUBLE_CLICK_RESET, LONG_PRESS_RESET};
   logic        btn_level = 1'b1;
   logic        btn_held = 1'b0;
   logic        long_seen = 1'b0;
   logic        tally_armed = 1'b0;
   logic [1:0]  tally = 2'd0;
   logic [31:0] last_edge_t = 32'd0;
   logic [31:0] press_t = 32'd0;
   logic [31:0] release_t = 32'd0;

   poll_type          poll_queue[$];
   gesture_type       gesture_q[$];
   poll_type          next_poll;
   gesture_type       want;
   longint unsigned   now_us = 0;
   int                polls_sent = 0;
   int                polls_taken = 0;
   int                results_seen = 0;
   int                fail_count = 0;
   int                cycle_count = 0;
   int                phase = 0;
   logic              req_fire = 1'b0;
   logic              steady = 1'b0;
   logic              rsp_hold;

   function automatic gesture_type next_gesture(input logic level, input logic [31:0] now);
      gesture_type found;
      logic [31:0] since_edge;
      logic [31:0] since_press;
      logic [31:0] since_release;
      found = GESTURE_NONE;
      since_edge = now - last_edge_t;
      if (level != btn_level && since_edge > 32'(shadow_cfg.debounce_us)) begin
         last_edge_t = now;
         if (level == 1'b0) begin
            press_t = now;
            btn_held = 1'b1;
            long_seen = 1'b0;
         end else begin
            release_t = now;
            btn_held = 1'b0;
            if (!long_seen) begin
               if (tally != 2'd3) tally = tally + 2'd1;
               tally_armed = 1'b1;
            end
         end
         btn_level = level;
      end
      since_press = now - press_t;
      if (btn_held && !long_seen && since_press > 32'(shadow_cfg.long_press_us)) begin
         long_seen = 1'b1;
         tally = 2'd0;
         found = GESTURE_LONG;
      end
      since_release = now - release_t;
      if (tally_armed && !btn_held && since_release > 32'(shadow_cfg.double_click_us)) begin
         tally_armed = 1'b0;
         if (tally == 2'd1) found = GESTURE_SINGLE;
         else if (tally == 2'd2) found = GESTURE_DOUBLE;
         tally = 2'd0;
      end
      return found;
   endfunction

   task automatic push_poll(input logic level, input longint unsigned at);
      poll_type p;
      now_us = at;
      p.pin_level = level;
      p.time_us = now_us[31:0];
      poll_queue.push_back(p);
      polls_sent++;
   endtask

   // presses of a gesture, each with an optional bounce inside the debounce window
   task automatic add_clicks(input int presses, input bit hold_long);
      longint unsigned deb, dbl, lng, span, press_at, bounce, gap;
      deb = shadow_cfg.debounce_us;
      dbl = shadow_cfg.double_click_us;
      lng = shadow_cfg.long_press_us;
      for (int i = 0; i < presses; i++) begin
         push_poll(1'b0, now_us + deb + 1 + $urandom_range(0, 2));
         press_at = now_us;
         if (hold_long) span = lng + 1 + $urandom_range(0, 3);
         else if (lng > deb + 1) span = deb + 1 + $urandom_range(0, 32'(lng - deb - 1));
         else span = deb + 1;
         bounce = $urandom_range(0, 32'(deb));
         if ($urandom_range(0, 1) && bounce < span) begin
            push_poll(1'b1, press_at + bounce);
            push_poll(1'b0, now_us);
         end
         push_poll(1'b0, press_at + span);
         push_poll(1'b1, now_us + $urandom_range(0, 2));
         if (i < presses - 1) begin
            gap = (dbl > deb + 1) ? dbl - deb - 1 : 0;
            now_us = now_us + $urandom_range(0, 32'(gap));
         end
      end
      push_poll(1'b1, now_us + dbl + 1 + $urandom_range(0, 2));
   endtask

   task automatic add_random_polls(input int count);
      int stop;
      longint unsigned deb;
      stop = polls_sent + count;
      while (polls_sent < stop) begin
         deb = shadow_cfg.debounce_us;
         case ($urandom_range(0, 11))
            0: push_poll(1'($urandom_range(0, 1)), now_us + $urandom_range(0, 32'(2 * deb + 2)));
            1: push_poll(1'($urandom_range(0, 1)), longint'($urandom));
            2: begin
               push_poll(1'b0, now_us + deb + 1);
               push_poll(1'b1, now_us + $urandom_range(0, 32'(deb)));
            end
            3: begin
               now_us = 64'h1_0000_0000 - $urandom_range(1, 32'(shadow_cfg.long_press_us
                        + shadow_cfg.double_click_us + 2));
               add_clicks($urandom_range(1, 2), 1'($urandom_range(0, 1)));
            end
            4: add_clicks(1, 1'b1);
            5, 6: add_clicks(1, 1'b0);
            7, 8, 9: add_clicks(2, 1'b0);
            default: add_clicks($urandom_range(3, 4), 1'b0);
         endcase
      end
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      forever begin
         @(posedge clock);
         if (csr_bus.ready) break;
      end
      case (idx)
         REG_DEBOUNCE:     shadow_cfg.debounce_us = val;
         REG_DOUBLE_CLICK: shadow_cfg.double_click_us = val;
         REG_LONG_PRESS:   shadow_cfg.long_press_us = val;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_BITS-1:0] deb, input logic [CFG_BITS-1:0] dbl,
                             input logic [CFG_BITS-1:0] lng);
      write_reg(REG_DEBOUNCE, deb);
      write_reg(REG_DOUBLE_CLICK, dbl);
      write_reg(REG_LONG_PRESS, lng);
   endtask

   // poll source
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (poll_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
            next_poll = poll_queue.pop_front();
            req_bus.pin_level <= next_poll.pin_level;
            req_bus.time_us <= next_poll.time_us;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result sink
   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !rsp_hold && (steady || $urandom_range(0, 99) >= 27);
   end

   initial begin
      rsp_hold = 1'b0;
      wait (phase == 3 && polls_sent - polls_taken > 150);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   // beat monitor and checker
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_fire = req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (gesture_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: result beat %0d with none pending", rsp_bus.gesture);
            end else begin
               want = gesture_q.pop_front();
               results_seen++;
               if (rsp_bus.gesture !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: result %0d expected gesture %0d got %0d",
                              results_seen, want, rsp_bus.gesture);
               end
            end
         end
         if (req_fire) begin
            gesture_q.push_back(next_gesture(req_bus.pin_level, req_bus.time_us));
            polls_taken++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pin_level = 1'b1;
      req_bus.time_us = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_DEBOUNCE;
      csr_bus.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: debounce and click window boundaries, then gestures
      phase = 1;
      push_poll(1'b1, 0);
      push_poll(1'b0, 50000);
      push_poll(1'b0, 50001);
      push_poll(1'b1, 100001);
      push_poll(1'b1, 100002);
      push_poll(1'b1, 400002);
      push_poll(1'b1, 400003);
      add_clicks(2, 1'b0);
      add_clicks(1, 1'b1);
      now_us = 64'hFFFF_FFFF - 400000;
      push_poll(1'b1, 64'hFFFF_FFFF);
      add_clicks(3, 1'b0);
      wait (results_seen == polls_sent);

      phase = 2;
      set_config(24'd3, 24'd40, 24'd120);
      write_reg(REG_UNUSED, CFG_BITS'($urandom));
      steady <= 1'b1;
      add_random_polls(215);
      wait (results_seen == polls_sent);
      steady <= 1'b0;

      phase = 3;
      set_config(24'd0, 24'd0, 24'd0);
      add_random_polls(215);
      wait (results_seen == polls_sent);

      phase = 4;
      set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      add_random_polls(215);
      wait (results_seen == polls_sent);

      phase = 5;
      set_config(CFG_BITS'($urandom_range(0, 200)), CFG_BITS'($urandom_range(0, 2000)),
                 CFG_BITS'($urandom_range(0, 5000)));
      add_random_polls(215);
      wait (results_seen == polls_sent);

      phase = 6;
      set_config(24'd1, 24'hFFFFFF, 24'd0);
      add_random_polls(215);
      wait (results_seen == polls_sent);

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/bcgd_pkg.sv
hw/rtl/bcgd_if.sv
hw/rtl/bcgd_core.sv
hw/rtl/button_click_gesture_detector_top.sv
tb/tb_button_click_gesture_detector_top.sv
